[rtl/hermite_tension_bias_interp_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the Hermite interpolator
// Short forms for the concurrent checks written at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef HERMITE_TENSION_BIAS_INTERP_MACROS_SVH
`define HERMITE_TENSION_BIAS_INTERP_MACROS_SVH

// Same-cycle implication, switched off while reset is asserted.
`define HTBI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is asserted.
`define HTBI_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/htbi_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// htbi_pkg
// Widths, constants and beat types of the Hermite tension/bias interpolator.
// ----------------------------------------------------------------------------
package htbi_pkg;

    localparam int SAMPLE_WIDTH       = 16;
    localparam int POSITION_FRAC_BITS = 16;
    localparam int CFG_WIDTH          = 16;
    localparam int CFG_INDEX_WIDTH    = 2;

    localparam int SW = SAMPLE_WIDTH;
    localparam int PF = POSITION_FRAC_BITS;
    localparam int PW = PF + 1;

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_TENSION = CFG_INDEX_WIDTH'(0);
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_BIAS    = CFG_INDEX_WIDTH'(1);

    // One in Q2.14 and one in Q1.PF.
    localparam int Q14_ONE = 16384;
    localparam logic [PW-1:0] POS_ONE = {1'b1, {PF{1'b0}}};

    localparam logic signed [SW-1:0] SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};

    typedef struct packed {
        logic [PW-1:0]        position;
        logic signed [SW-1:0] sample_before;
        logic signed [SW-1:0] sample_start;
        logic signed [SW-1:0] sample_end;
        logic signed [SW-1:0] sample_after;
    } t_in_beat;

    typedef struct packed {
        logic signed [SW-1:0] value;
        logic                 clipped;
    } t_out_beat;

endpackage
`default_nettype wire

[rtl/hermite_tension_bias_interp.sv]
`default_nettype none
`include "hermite_tension_bias_interp_macros.svh"
// ----------------------------------------------------------------------------
// hermite_tension_bias_interp
// Cubic Hermite interpolator with tension and bias, seven-stage pipeline.
// Each input beat carries four neighboring samples and a position between
// the middle two; each output beat carries the interpolated sample, rounded
// and saturated to the sample range, and a flag that is set when saturation
// happened. The block accepts one beat per clock while the input is not
// stalled; each beat passes through the chain of multiply and rounding
// steps, each of which owns one register stage. A stall on the
// output freezes only the stages that are full, so bubbles are squeezed out
// and the input keeps flowing while the output register holds a waiting beat.
// Tension and bias are written through the configuration port, which is
// always ready; they should only be changed while no beat is in flight.
// ----------------------------------------------------------------------------
module hermite_tension_bias_interp
    import htbi_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // Configuration writes.
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  wire logic [CFG_WIDTH-1:0]       i_cfg_data,
    // Input beats.
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire t_in_beat                   i_in_beat,
    // Output beats.
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output t_out_beat                       o_out_beat
);

    // Arithmetic widths. Every width follows from the sample, position and configuration widths.
    localparam int NSTAGE = 7;
    localparam int DW     = SW + 1;            // sample difference
    localparam int KW     = CFG_WIDTH + 1;     // 1 +/- bias, (1 - tension)/2
    localparam int PRW    = DW + KW;           // difference times bias factor
    localparam int SUMW   = PRW + 1;           // tangent sum in Q14
    localparam int S4W    = SUMW + 1 - 10;     // tangent sum rounded to Q4
    localparam int QW     = S4W + KW;          // Q4 times Q15
    localparam int MW     = QW + 1 - 15;       // tangent in Q4
    localparam int AW     = PF + 4;            // basis weight, signed
    localparam int YPW    = AW + SW;           // weight times sample
    localparam int MPW    = AW + MW;           // weight times tangent
    localparam int ACCW   = MPW + 2;           // weighted sum in Q(PF+4)
    localparam int VW     = ACCW + 1 - (PF + 4);

    localparam logic [2*PW-1:0]        RND_POS = (2*PW)'(1) << (PF - 1);
    localparam logic signed [SUMW:0]   RND_10  = (SUMW+1)'(1) <<< 9;
    localparam logic signed [QW:0]     RND_15  = (QW+1)'(1) <<< 14;
    localparam logic signed [ACCW:0]   RND_ACC = (ACCW+1)'(1) <<< (PF + 3);
    localparam logic signed [VW-1:0]   VMAX    = VW'(SAMPLE_MAX);
    localparam logic signed [VW-1:0]   VMIN    = VW'(SAMPLE_MIN);

    // ------------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------------
    logic signed [CFG_WIDTH-1:0] r_tension;
    logic signed [CFG_WIDTH-1:0] r_bias;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tension <= '0;
            r_bias    <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_TENSION: r_tension <= $signed(i_cfg_data);
                REG_BIAS:    r_bias    <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    // Factors shared by both tangents. Change them only while the pipe is empty; the block does not enforce it.
    logic signed [KW-1:0] w_bias_p;    // 1 + bias, Q14
    logic signed [KW-1:0] w_bias_m;    // 1 - bias, Q14
    logic signed [KW-1:0] w_half_t;    // (1 - tension) / 2, Q15

    assign w_bias_p = KW'(Q14_ONE) + KW'(r_bias);
    assign w_bias_m = KW'(Q14_ONE) - KW'(r_bias);
    assign w_half_t = KW'(Q14_ONE) - KW'(r_tension);

    // ------------------------------------------------------------------------
    // Flow control. A stage takes new contents when it is empty or when the
    // stage after it takes its present contents.
    // ------------------------------------------------------------------------
    logic [NSTAGE-1:0] r_vld;
    logic [NSTAGE-1:0] w_rdy;

    always_comb begin
        w_rdy[NSTAGE-1] = !r_vld[NSTAGE-1] || !i_out_stall;
        for (int k = NSTAGE - 2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    assign o_in_stall = !w_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NSTAGE; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stage 1: clamp the position, square it, take the sample differences.
    // ------------------------------------------------------------------------
    logic [PW-1:0]          w_mu;
    logic [PW-1:0]          r1_mu;
    logic [2*PW-1:0]        r1_mu_sq;
    logic signed [SW-1:0]   r1_y1;
    logic signed [SW-1:0]   r1_y2;
    logic signed [DW-1:0]   r1_d0;
    logic signed [DW-1:0]   r1_d1;
    logic signed [DW-1:0]   r1_d2;

    // Positions past one are treated as exactly one.
    assign w_mu = (i_in_beat.position > POS_ONE) ? POS_ONE : i_in_beat.position;

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r1_mu    <= w_mu;
            r1_mu_sq <= (2*PW)'(w_mu) * (2*PW)'(w_mu);
            r1_y1    <= i_in_beat.sample_start;
            r1_y2    <= i_in_beat.sample_end;
            r1_d0    <= DW'(i_in_beat.sample_start) - DW'(i_in_beat.sample_before);
            r1_d1    <= DW'(i_in_beat.sample_end) - DW'(i_in_beat.sample_start);
            r1_d2    <= DW'(i_in_beat.sample_after) - DW'(i_in_beat.sample_end);
        end
    end

    // ------------------------------------------------------------------------
    // Stage 2: round mu squared and cube it; weight the differences by bias.
    // ------------------------------------------------------------------------
    logic [PW-1:0]          w_mu2;
    logic [PW-1:0]          r2_mu;
    logic [PW-1:0]          r2_mu2;
    logic [2*PW-1:0]        r2_mu3_raw;
    logic signed [PRW-1:0]  r2_p0;
    logic signed [PRW-1:0]  r2_p1;
    logic signed [PRW-1:0]  r2_p2;
    logic signed [PRW-1:0]  r2_p3;
    logic signed [SW-1:0]   r2_y1;
    logic signed [SW-1:0]   r2_y2;

    assign w_mu2 = PW'((r1_mu_sq + RND_POS) >> PF);

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r2_mu      <= r1_mu;
            r2_mu2     <= w_mu2;
            r2_mu3_raw <= (2*PW)'(w_mu2) * (2*PW)'(r1_mu);
            r2_p0      <= PRW'(r1_d0) * PRW'(w_bias_p);
            r2_p1      <= PRW'(r1_d1) * PRW'(w_bias_m);
            r2_p2      <= PRW'(r1_d1) * PRW'(w_bias_p);
            r2_p3      <= PRW'(r1_d2) * PRW'(w_bias_m);
            r2_y1      <= r1_y1;
            r2_y2      <= r1_y2;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 3: tangent sums rounded to Q4; the four Hermite basis weights.
    // ------------------------------------------------------------------------
    logic signed [SUMW:0]   w_s0;
    logic signed [SUMW:0]   w_s1;
    logic [PW-1:0]          w_mu3;
    logic signed [AW-1:0]   w_mu_s;
    logic signed [AW-1:0]   w_mu2_s;
    logic signed [AW-1:0]   w_mu3_s;
    logic signed [AW-1:0]   w_one_s;
    logic signed [S4W-1:0]  r3_s0;
    logic signed [S4W-1:0]  r3_s1;
    logic signed [AW-1:0]   r3_a0;
    logic signed [AW-1:0]   r3_a1;
    logic signed [AW-1:0]   r3_a2;
    logic signed [AW-1:0]   r3_a3;
    logic signed [SW-1:0]   r3_y1;
    logic signed [SW-1:0]   r3_y2;

    assign w_s0 = (SUMW+1)'(r2_p0) + (SUMW+1)'(r2_p1) + RND_10;
    assign w_s1 = (SUMW+1)'(r2_p2) + (SUMW+1)'(r2_p3) + RND_10;

    assign w_mu3   = PW'((r2_mu3_raw + RND_POS) >> PF);
    assign w_mu_s  = AW'($signed({1'b0, r2_mu}));
    assign w_mu2_s = AW'($signed({1'b0, r2_mu2}));
    assign w_mu3_s = AW'($signed({1'b0, w_mu3}));
    assign w_one_s = AW'($signed({1'b0, POS_ONE}));

    always_ff @(posedge i_clk) begin
        if (w_rdy[2]) begin
            r3_s0 <= S4W'(w_s0 >>> 10);
            r3_s1 <= S4W'(w_s1 >>> 10);
            // a0 = 2mu3 - 3mu2 + 1, a1 = mu3 - 2mu2 + mu,
            // a2 = mu3 - mu2,       a3 = 3mu2 - 2mu3.
            r3_a0 <= (w_mu3_s <<< 1) - (w_mu2_s + (w_mu2_s <<< 1)) + w_one_s;
            r3_a1 <= w_mu3_s - (w_mu2_s <<< 1) + w_mu_s;
            r3_a2 <= w_mu3_s - w_mu2_s;
            r3_a3 <= (w_mu2_s + (w_mu2_s <<< 1)) - (w_mu3_s <<< 1);
            r3_y1 <= r2_y1;
            r3_y2 <= r2_y2;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 4: apply tension to the tangents; weight the two end samples.
    // ------------------------------------------------------------------------
    logic signed [QW-1:0]   r4_q0;
    logic signed [QW-1:0]   r4_q1;
    logic signed [AW-1:0]   r4_a1;
    logic signed [AW-1:0]   r4_a2;
    logic signed [YPW-1:0]  r4_ya0;
    logic signed [YPW-1:0]  r4_ya3;

    always_ff @(posedge i_clk) begin
        if (w_rdy[3]) begin
            r4_q0  <= QW'(r3_s0) * QW'(w_half_t);
            r4_q1  <= QW'(r3_s1) * QW'(w_half_t);
            r4_a1  <= r3_a1;
            r4_a2  <= r3_a2;
            r4_ya0 <= YPW'(r3_a0) * YPW'(r3_y1);
            r4_ya3 <= YPW'(r3_a3) * YPW'(r3_y2);
        end
    end

    // ------------------------------------------------------------------------
    // Stage 5: round the tangents to Q4 and weight them; add the two weighted end samples.
    // ------------------------------------------------------------------------
    logic signed [QW:0]     w_q0_r;
    logic signed [QW:0]     w_q1_r;
    logic signed [MW-1:0]   w_m0;
    logic signed [MW-1:0]   w_m1;
    logic signed [MPW-1:0]  r5_pa1;
    logic signed [MPW-1:0]  r5_pa2;
    logic signed [YPW:0]    r5_ys;

    assign w_q0_r = (QW+1)'(r4_q0) + RND_15;
    assign w_q1_r = (QW+1)'(r4_q1) + RND_15;
    assign w_m0   = MW'(w_q0_r >>> 15);
    assign w_m1   = MW'(w_q1_r >>> 15);

    always_ff @(posedge i_clk) begin
        if (w_rdy[4]) begin
            r5_pa1 <= MPW'(r4_a1) * MPW'(w_m0);
            r5_pa2 <= MPW'(r4_a2) * MPW'(w_m1);
            r5_ys  <= (YPW+1)'(r4_ya0) + (YPW+1)'(r4_ya3);
        end
    end

    // ------------------------------------------------------------------------
    // Stage 6: the weighted sum, exact in Q(PF+4). Samples are in Q0 and the
    // tangents in Q4, so the sample terms move up by four bits.
    // ------------------------------------------------------------------------
    logic signed [ACCW-1:0] r6_acc;

    always_ff @(posedge i_clk) begin
        if (w_rdy[5]) begin
            r6_acc <= (ACCW'(r5_ys) <<< 4) + ACCW'(r5_pa1) + ACCW'(r5_pa2);
        end
    end

    // ------------------------------------------------------------------------
    // Stage 7: round half up to an integer and saturate. This is the output
    // register that holds a beat while the output is stalled.
    // ------------------------------------------------------------------------
    logic signed [ACCW:0]   w_acc_r;
    logic signed [VW-1:0]   w_v;
    t_out_beat              w_out;
    t_out_beat              r7_out;

    assign w_acc_r = (ACCW+1)'(r6_acc) + RND_ACC;
    assign w_v     = VW'(w_acc_r >>> (PF + 4));

    always_comb begin
        if (w_v > VMAX) begin
            w_out.value   = SAMPLE_MAX;
            w_out.clipped = 1'b1;
        end else if (w_v < VMIN) begin
            w_out.value   = SAMPLE_MIN;
            w_out.clipped = 1'b1;
        end else begin
            w_out.value   = SW'(w_v);
            w_out.clipped = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[6]) begin
            r7_out <= w_out;
        end
    end

    assign o_out_valid = r_vld[NSTAGE-1];
    assign o_out_beat  = r7_out;

    // ------------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------------
    // The input is held off only when every stage holds a beat.
    `HTBI_ASSERT_IMP(a_stall_only_full, i_clk, i_rst_n, o_in_stall, &r_vld, "input stalled with an empty stage")

    // A beat moving out of the middle of the pipe lands in the next stage.
    `HTBI_ASSERT_NXT(a_mid_advance, i_clk, i_rst_n, r_vld[2] && w_rdy[3], r_vld[3], "beat lost between stages")

    // A clipped result sits exactly on one of the range limits.
    `HTBI_ASSERT_IMP(a_clip_at_limit, i_clk, i_rst_n, o_out_valid && o_out_beat.clipped, o_out_beat.value == SAMPLE_MAX || o_out_beat.value == SAMPLE_MIN, "clipped value off the range limits")

endmodule
`default_nettype wire

[tb/sv/tb_hermite_tension_bias_interp.sv]
// ----------------------------------------------------------------------------
// tb_hermite_tension_bias_interp
// Self-checking bench for the Hermite tension/bias interpolator. A queue-fed
// driver offers input beats. A clocked monitor predicts each accepted beat
// in fixed point and compares every output beat, field by field, against the
// oldest prediction. The run steps through several tension/bias settings,
// the extremes among them, and several idle patterns on both sides.
// ----------------------------------------------------------------------------
module tb_hermite_tension_bias_interp;
    import htbi_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Index codes that address no register; writes to them must be ignored.
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_A = CFG_INDEX_WIDTH'(2);
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_B = CFG_INDEX_WIDTH'(3);

    localparam int NUM_PHASES     = 9;
    localparam int RANDOM_PER_SET = 90;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int DRAIN_CYCLES   = 10;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                       cfg_valid = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CFG_WIDTH-1:0]       cfg_data = '0;
    logic                       o_cfg_ready;

    logic      in_valid = 1'b0;
    t_in_beat  in_beat = '0;
    logic      o_in_stall;

    logic      o_out_valid;
    logic      out_stall = 1'b0;
    t_out_beat o_out_beat;

    hermite_tension_bias_interp dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_beat   (in_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_beat  (o_out_beat)
    );

    // Beats waiting to be offered, and interpolated points waiting to come out.
    t_in_beat  pending_beats[$];
    t_out_beat expected_points[$];

    // The bench's own copy of the two registers.
    logic signed [CFG_WIDTH-1:0] cur_tension = '0;
    logic signed [CFG_WIDTH-1:0] cur_bias = '0;

    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   hold_requests = 0;
    int   hold_seen = 0;
    int   hold_left = 0;
    int   mismatch_count = 0;
    logic beat_taken = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Round half up of x / 2^n. An arithmetic shift of a signed value is a
    // floor, so adding half first gives the rounding we want.
    function automatic longint round_up_shift(input longint x, input int n);
        return (x + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    // One tangent in Q4: the biased blend of two differences is taken from
    // Q14 down to Q4, then scaled by (1 - tension) / 2, which is Q15.
    function automatic longint tangent_q4(input longint d_first, input longint d_second,
                                          input longint half_tension,
                                          input longint bias_q14);
        longint blend;
        blend = d_first * (Q14_ONE + bias_q14) + d_second * (Q14_ONE - bias_q14);
        return round_up_shift(round_up_shift(blend, 10) * half_tension, 15);
    endfunction

    // Expected output beat for one input beat under the current registers.
    function automatic t_out_beat hermite_point(input t_in_beat b,
                                                input logic signed [CFG_WIDTH-1:0] ten,
                                                input logic signed [CFG_WIDTH-1:0] bs);
        longint one_q, mu, y0, y1, y2, y3, half_t, m0, m1, mu2, mu3;
        longint a0, a1, a2, a3, acc, v;
        t_out_beat r;
        one_q = longint'(1) <<< PF;
        mu = longint'(b.position);
        y0 = longint'(b.sample_before);
        y1 = longint'(b.sample_start);
        y2 = longint'(b.sample_end);
        y3 = longint'(b.sample_after);
        // Positions past one are pinned to the segment end.
        if (mu > one_q) begin
            mu = one_q;
        end
        half_t = Q14_ONE - longint'(ten);
        m0 = tangent_q4(y1 - y0, y2 - y1, half_t, longint'(bs));
        m1 = tangent_q4(y2 - y1, y3 - y2, half_t, longint'(bs));
        mu2 = round_up_shift(mu * mu, PF);
        mu3 = round_up_shift(mu2 * mu, PF);
        a0 = 2 * mu3 - 3 * mu2 + one_q;
        a1 = mu3 - 2 * mu2 + mu;
        a2 = mu3 - mu2;
        a3 = 3 * mu2 - 2 * mu3;
        acc = (a0 * y1 + a3 * y2) * 16 + a1 * m0 + a2 * m1;
        v = round_up_shift(acc, PF + 4);
        r.clipped = 1'b0;
        if (v > longint'(SAMPLE_MAX)) begin
            v = longint'(SAMPLE_MAX);
            r.clipped = 1'b1;
        end else if (v < longint'(SAMPLE_MIN)) begin
            v = longint'(SAMPLE_MIN);
            r.clipped = 1'b1;
        end
        r.value = SW'(v);
        return r;
    endfunction

    function automatic logic signed [SW-1:0] to_sample(input int x);
        if (x > int'(SAMPLE_MAX)) begin
            return SAMPLE_MAX;
        end else if (x < int'(SAMPLE_MIN)) begin
            return SAMPLE_MIN;
        end
        return SW'(x);
    endfunction

    function automatic t_in_beat make_beat(input logic [PW-1:0] pos,
                                           input logic signed [SW-1:0] before_s,
                                           input logic signed [SW-1:0] start_s,
                                           input logic signed [SW-1:0] end_s,
                                           input logic signed [SW-1:0] after_s);
        t_in_beat b;
        b.position      = pos;
        b.sample_before = before_s;
        b.sample_start  = start_s;
        b.sample_end    = end_s;
        b.sample_after  = after_s;
        return b;
    endfunction

    // A sample scattered around a base value, for smooth curves.
    function automatic logic signed [SW-1:0] near_sample(input int base, input int spread);
        return to_sample(base + int'($urandom_range(2 * spread)) - spread);
    endfunction

    // Full scale, either way, or anything at all.
    function automatic logic signed [SW-1:0] extreme_or_any();
        int pick;
        pick = $urandom_range(2);
        if (pick == 0) begin
            return SAMPLE_MAX;
        end else if (pick == 1) begin
            return SAMPLE_MIN;
        end
        return SW'($urandom);
    endfunction

    function automatic t_in_beat random_beat();
        int pick, base, spread;
        logic [PW-1:0] pos;
        pick = $urandom_range(99);
        if (pick < 8) begin
            pos = '0;
        end else if (pick < 16) begin
            pos = POS_ONE;
        end else if (pick < 24) begin
            pos = PW'($urandom_range(2 ** PW - 1, 2 ** PF + 1));
        end else begin
            pos = PW'($urandom_range(2 ** PF));
        end
        pick = $urandom_range(99);
        if (pick < 55) begin
            // Smooth neighborhood, the usual case for resampling.
            base = int'($urandom_range(65535)) - 32768;
            spread = 1 << $urandom_range(14);
            return make_beat(pos, near_sample(base, spread), near_sample(base, spread),
                             near_sample(base, spread), near_sample(base, spread));
        end else if (pick < 85) begin
            return make_beat(pos, SW'($urandom), SW'($urandom), SW'($urandom),
                             SW'($urandom));
        end
        return make_beat(pos, extreme_or_any(), extreme_or_any(), extreme_or_any(),
                         extreme_or_any());
    endfunction

    // Endpoints, positions past one, full-scale samples and curves that
    // overshoot in both directions so that the result has to saturate.
    task automatic queue_directed();
        pending_beats.push_back(make_beat('0, 100, -200, 300, 400));
        pending_beats.push_back(make_beat(POS_ONE, 100, -200, 300, 400));
        pending_beats.push_back(make_beat(PW'(POS_ONE + 1), 100, -200, 300, 400));
        pending_beats.push_back(make_beat('1, -5, 7, -9, 11));
        pending_beats.push_back(make_beat(PW'(1), 1000, -1000, 1000, -1000));
        pending_beats.push_back(make_beat(PW'(POS_ONE - 1), 1000, -1000, 1000, -1000));
        pending_beats.push_back(make_beat(POS_ONE >> 1, SAMPLE_MAX, SAMPLE_MAX,
                                          SAMPLE_MAX, SAMPLE_MAX));
        pending_beats.push_back(make_beat(POS_ONE >> 1, SAMPLE_MIN, SAMPLE_MIN,
                                          SAMPLE_MIN, SAMPLE_MIN));
        pending_beats.push_back(make_beat(POS_ONE >> 1, SAMPLE_MIN, SAMPLE_MAX,
                                          SAMPLE_MAX, SAMPLE_MIN));
        pending_beats.push_back(make_beat(POS_ONE >> 1, SAMPLE_MAX, SAMPLE_MIN,
                                          SAMPLE_MIN, SAMPLE_MAX));
        pending_beats.push_back(make_beat(POS_ONE >> 2, SAMPLE_MIN, SAMPLE_MIN,
                                          SAMPLE_MAX, SAMPLE_MAX));
        pending_beats.push_back(make_beat(PW'(49152), SAMPLE_MAX, SAMPLE_MAX,
                                          SAMPLE_MIN, SAMPLE_MIN));
        pending_beats.push_back(make_beat('0, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN,
                                          SAMPLE_MAX));
        pending_beats.push_back(make_beat(POS_ONE, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX,
                                          SAMPLE_MIN));
        pending_beats.push_back(make_beat(PW'(12345), 0, 0, 0, 0));
        pending_beats.push_back(make_beat(PW'(POS_ONE - 1), -1, -1, -1, -1));
    endtask

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%0t ns: %s", $realtime, msg);
        end
    endtask

    // One register write; the bench's copy follows at the handshake edge.
    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                             input logic [CFG_WIDTH-1:0] data);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_TENSION: begin
                cur_tension = data;
            end
            REG_BIAS: begin
                cur_bias = data;
            end
            default: begin
            end
        endcase
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // Holds the sender back until every offered beat has come out, then
    // lets the pipeline idle. Checks run a step after the
    // rising edge so that the monitor and the driver have settled.
    task automatic wait_drained();
        do begin
            @(posedge i_clk);
            #1;
        end while (pending_beats.size() != 0 || in_valid || expected_points.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        #1;
    endtask

    // Driver: a beat stays on the bus until the edge that takes it; only
    // then may the next one, or a gap, follow.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || beat_taken) begin
            if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                in_valid <= 1'b1;
                in_beat  <= pending_beats.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off whenever one is asked
    // for. The hold-off is counted here in clock cycles.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_requests) begin
            hold_seen <= hold_requests;
            hold_left <= HOLDOFF_CYCLES;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Monitor: every accepted input beat gets its prediction queued, and
    // every accepted output beat is checked against the oldest one.
    always @(posedge i_clk) begin
        t_out_beat want;
        if (!i_rst_n) begin
            beat_taken <= 1'b0;
        end else begin
            beat_taken <= in_valid && !o_in_stall;
            if (in_valid && !o_in_stall) begin
                expected_points.push_back(hermite_point(in_beat, cur_tension, cur_bias));
            end
            if (o_out_valid && !out_stall) begin
                if (expected_points.size() == 0) begin
                    flag_mismatch($sformatf("output beat with nothing expected: value %0d clipped %0b",
                                            o_out_beat.value, o_out_beat.clipped));
                end else begin
                    want = expected_points.pop_front();
                    if (o_out_beat.value !== want.value) begin
                        flag_mismatch($sformatf("value: expected %0d, got %0d",
                                                want.value, o_out_beat.value));
                    end
                    if (o_out_beat.clipped !== want.clipped) begin
                        flag_mismatch($sformatf("clipped: expected %0b, got %0b",
                                                want.clipped, o_out_beat.clipped));
                    end
                end
            end
        end
    end

    // Stimulus. Each phase waits for the pipeline to empty, sets both
    // registers, and then queues the directed beats and a random batch. The
    // first three phases idle the sender lightly and the receiver heavily,
    // the next three the other way round, the last three not at all. Every
    // third phase also asks the receiver for a long hold-off so that the
    // pipeline fills and pushes back on the input.
    initial begin
        static int tension_set[NUM_PHASES] =
            '{0, 32767, -32768, -32768, 32767, 8192, 0, -16384, 0};
        static int bias_set[NUM_PHASES] =
            '{0, 32767, -32768, 32767, -32768, -4096, 0, 12000, 0};
        logic [CFG_WIDTH-1:0] ten_word, bias_word;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_drained();
            send_idle_pct = (ph < 3) ? 25 : (ph < 6) ? 53 : 0;
            recv_idle_pct = (ph < 3) ? 53 : (ph < 6) ? 25 : 0;
            ten_word  = CFG_WIDTH'(tension_set[ph]);
            bias_word = CFG_WIDTH'(bias_set[ph]);
            // One setting is drawn at random.
            if (ph == 6) begin
                ten_word  = CFG_WIDTH'($urandom);
                bias_word = CFG_WIDTH'($urandom);
            end
            write_reg(REG_TENSION, ten_word);
            write_reg(REG_BIAS, bias_word);
            // Writes to unused indexes must leave both registers alone.
            if (ph % 3 == 1) begin
                write_reg((ph < 4) ? REG_SPARE_A : REG_SPARE_B, CFG_WIDTH'($urandom));
            end
            @(posedge i_clk);
            #1;
            queue_directed();
            for (int n = 0; n < RANDOM_PER_SET; n++) begin
                pending_beats.push_back(random_beat());
            end
            if (ph % 3 == 2) begin
                hold_requests++;
            end
        end
        wait_drained();

        if (expected_points.size() != 0) begin
            flag_mismatch($sformatf("%0d expected beats never arrived",
                                    expected_points.size()));
        end
        if (mismatch_count == 0) begin
            $display("hermite_tension_bias_interp regression: pass");
        end else begin
            $display("hermite_tension_bias_interp regression: fail");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("hermite_tension_bias_interp regression: fail");
        $finish;
    end

endmodule
